/* hw/rtl/ctbp_pkg.sv */
// Shared constants and types for the committed access rate token bucket policer.
package ctbp_pkg;

  localparam int DEF_TIME_WIDTH       = 48;
  localparam int DEF_BYTE_COUNT_WIDTH = 32;

  localparam int RATE_WIDTH      = 24;
  localparam int LEN_WIDTH       = 16;
  localparam int COLOUR_WIDTH    = 3;
  localparam int OUT_TDATA_WIDTH = 8;
  localparam int CFG_IDX_WIDTH   = 2;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_COMMITTED_RATE  = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_COMMITTED_BURST = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_EXTENDED_BURST  = 2'd2;

  typedef enum logic [COLOUR_WIDTH-1:0] {
    COLOUR_GREEN          = 3'd0,
    COLOUR_YELLOW         = 3'd1,
    COLOUR_RED_ACTUAL     = 3'd2,
    COLOUR_RED_COMPOUNDED = 3'd3,
    COLOUR_BYPASSED       = 3'd4
  } colour_t;

  typedef struct packed {
    logic    pass;
    colour_t colour;
  } verdict_t;

endpackage

/* hw/rtl/car_token_bucket_policer_top.sv */
// Top level of the committed access rate token bucket policer with extended burst.
// A beat is registered in the input stage, then its verdict in the output stage.
// Throughput: one packet per cycle while out_tready holds; refill multiply and metering
// form one combinational path against the bucket state, which sets the clock period.
// Reset (rst_n low, synchronous): registers, bucket level, debt and refill time
// go to zero; both pipeline stages empty.
module car_token_bucket_policer_top #(
  parameter int TIME_WIDTH       = ctbp_pkg::DEF_TIME_WIDTH,
  parameter int BYTE_COUNT_WIDTH = ctbp_pkg::DEF_BYTE_COUNT_WIDTH,
  parameter int IN_TDATA_WIDTH   = ((TIME_WIDTH + ctbp_pkg::LEN_WIDTH + 7) / 8) * 8,
  parameter int CFG_DATA_WIDTH   =
    (BYTE_COUNT_WIDTH > ctbp_pkg::RATE_WIDTH) ? BYTE_COUNT_WIDTH : ctbp_pkg::RATE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [IN_TDATA_WIDTH-1:0]            in_tdata,   // now_ms, packet_bytes
  input  logic                                 in_tuser,   // already_blocked
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ctbp_pkg::OUT_TDATA_WIDTH-1:0] out_tdata,  // pass, colour
  input  logic                                 cfg_wr_en,
  input  logic [ctbp_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]            cfg_data
);
  import ctbp_pkg::*;

  logic [RATE_WIDTH-1:0]       rate_r;
  logic [BYTE_COUNT_WIDTH-1:0] cburst_r;
  logic [BYTE_COUNT_WIDTH-1:0] xburst_r;

  logic                        s1_valid_r, s1_valid_nxt;
  logic [TIME_WIDTH-1:0]       s1_now_r;
  logic [LEN_WIDTH-1:0]        s1_len_r;
  logic                        s1_blk_r;

  logic                        out_valid_r, out_valid_nxt;
  verdict_t                    out_verdict_r, out_verdict_nxt;

  logic [BYTE_COUNT_WIDTH:0]   level_r, level_nxt;
  logic [BYTE_COUNT_WIDTH-1:0] debt_r, debt_nxt;
  logic [TIME_WIDTH-1:0]       last_r, last_nxt;

  logic                        advance;
  logic                        accept;
  logic                        update;
  logic                        later;
  logic [BYTE_COUNT_WIDTH:0]   refilled;
  logic [BYTE_COUNT_WIDTH:0]   meter_level;
  logic [BYTE_COUNT_WIDTH-1:0] meter_debt;
  verdict_t                    meter_verdict;

  ctbp_refill #(
    .TIME_WIDTH       (TIME_WIDTH),
    .BYTE_COUNT_WIDTH (BYTE_COUNT_WIDTH)
  ) u_refill (
    .now_i   (s1_now_r),
    .last_i  (last_r),
    .level_i (level_r),
    .rate_i  (rate_r),
    .burst_i (cburst_r),
    .later_o (later),
    .level_o (refilled)
  );

  ctbp_meter #(
    .BYTE_COUNT_WIDTH (BYTE_COUNT_WIDTH)
  ) u_meter (
    .level_i   (refilled),
    .len_i     (s1_len_r),
    .xburst_i  (xburst_r),
    .debt_i    (debt_r),
    .verdict_o (meter_verdict),
    .level_o   (meter_level),
    .debt_o    (meter_debt)
  );

  always_comb begin
    advance         = !out_valid_r || out_tready;
    in_tready       = !s1_valid_r || advance;
    accept          = in_tvalid && in_tready;
    update          = s1_valid_r && advance && !s1_blk_r;
    s1_valid_nxt    = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt   = advance ? s1_valid_r : out_valid_r;
    out_verdict_nxt = s1_blk_r ? verdict_t'{pass: 1'b0, colour: COLOUR_BYPASSED}
                               : meter_verdict;
    level_nxt       = update ? meter_level : level_r;
    debt_nxt        = update ? meter_debt : debt_r;
    last_nxt        = (update && later) ? s1_now_r : last_r;
    out_tvalid      = out_valid_r;
    out_tdata       = {{(OUT_TDATA_WIDTH-1-COLOUR_WIDTH){1'b0}},
                       out_verdict_r.colour, out_verdict_r.pass};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= '0;
      cburst_r    <= '0;
      xburst_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      level_r     <= '0;
      debt_r      <= '0;
      last_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_COMMITTED_RATE:  rate_r   <= cfg_data[RATE_WIDTH-1:0];
          CFG_COMMITTED_BURST: cburst_r <= cfg_data[BYTE_COUNT_WIDTH-1:0];
          CFG_EXTENDED_BURST:  xburst_r <= cfg_data[BYTE_COUNT_WIDTH-1:0];
          default: ;
        endcase
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      level_r     <= level_nxt;
      debt_r      <= debt_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_now_r <= in_tdata[TIME_WIDTH-1:0];
      s1_len_r <= in_tdata[TIME_WIDTH+LEN_WIDTH-1:TIME_WIDTH];
      s1_blk_r <= in_tuser;
    end
    if (s1_valid_r && advance) begin
      out_verdict_r <= out_verdict_nxt;
    end
  end

endmodule

/* hw/rtl/ctbp_refill.sv */
// Bucket refill: elapsed time times rate, saturated, added and capped at the committed burst.
module ctbp_refill #(
  parameter int TIME_WIDTH       = ctbp_pkg::DEF_TIME_WIDTH,
  parameter int BYTE_COUNT_WIDTH = ctbp_pkg::DEF_BYTE_COUNT_WIDTH
) (
  input  logic [TIME_WIDTH-1:0]           now_i,
  input  logic [TIME_WIDTH-1:0]           last_i,
  input  logic [BYTE_COUNT_WIDTH:0]       level_i,
  input  logic [ctbp_pkg::RATE_WIDTH-1:0] rate_i,
  input  logic [BYTE_COUNT_WIDTH-1:0]     burst_i,
  output logic                            later_o,
  output logic [BYTE_COUNT_WIDTH:0]       level_o
);
  import ctbp_pkg::*;

  localparam int CW = BYTE_COUNT_WIDTH + 2;
  localparam int EW = (TIME_WIDTH < CW) ? TIME_WIDTH : CW;
  localparam int PW = EW + RATE_WIDTH;
  localparam int SW = BYTE_COUNT_WIDTH + 4;
  localparam logic [PW-1:0] CAP_P   = {{(PW-1){1'b0}}, 1'b1} << CW;
  localparam logic [CW:0]   CAP_REF = {{CW{1'b0}}, 1'b1} << CW;

  logic [TIME_WIDTH-1:0] elapsed;
  logic                  ovf;
  logic [PW-1:0]         prod;
  logic [CW:0]           refill;
  logic signed [SW-1:0]  sum;
  logic signed [SW-1:0]  burst_ext;

  always_comb begin
    later_o   = now_i > last_i;
    elapsed   = now_i - last_i;
    ovf       = (elapsed >> CW) != '0;
    prod      = PW'(elapsed[EW-1:0]) * PW'(rate_i);
    if ((ovf && (rate_i != '0)) || (prod > CAP_P)) begin
      refill = CAP_REF;
    end else begin
      refill = prod[CW:0];
    end
    sum       = $signed({{(SW-BYTE_COUNT_WIDTH-1){level_i[BYTE_COUNT_WIDTH]}}, level_i})
              + $signed({{(SW-CW-1){1'b0}}, refill});
    burst_ext = $signed({{(SW-BYTE_COUNT_WIDTH){1'b0}}, burst_i});
    if (!later_o) begin
      level_o = level_i;
    end else if (sum > burst_ext) begin
      level_o = {1'b0, burst_i};
    end else begin
      level_o = sum[BYTE_COUNT_WIDTH:0];
    end
  end

endmodule

/* hw/rtl/ctbp_meter.sv */
// Packet metering: green, yellow within the extended burst, or red on actual or compounded debt.
module ctbp_meter #(
  parameter int BYTE_COUNT_WIDTH = ctbp_pkg::DEF_BYTE_COUNT_WIDTH
) (
  input  logic [BYTE_COUNT_WIDTH:0]      level_i,
  input  logic [ctbp_pkg::LEN_WIDTH-1:0] len_i,
  input  logic [BYTE_COUNT_WIDTH-1:0]    xburst_i,
  input  logic [BYTE_COUNT_WIDTH-1:0]    debt_i,
  output ctbp_pkg::verdict_t             verdict_o,
  output logic [BYTE_COUNT_WIDTH:0]      level_o,
  output logic [BYTE_COUNT_WIDTH-1:0]    debt_o
);
  import ctbp_pkg::*;

  localparam int DW = BYTE_COUNT_WIDTH + 2;

  logic [DW-1:0]             diff;
  logic [DW-1:0]             neg_diff;
  logic [BYTE_COUNT_WIDTH:0] actual;
  logic [DW-1:0]             compounded;
  logic [DW-1:0]             xburst_ext;

  always_comb begin
    diff       = {level_i[BYTE_COUNT_WIDTH], level_i} - {{(DW-LEN_WIDTH){1'b0}}, len_i};
    neg_diff   = '0 - diff;
    actual     = neg_diff[BYTE_COUNT_WIDTH:0];
    compounded = {2'b00, debt_i} + {1'b0, actual};
    xburst_ext = {2'b00, xburst_i};
    level_o    = diff[BYTE_COUNT_WIDTH:0];
    debt_o     = debt_i;
    if (!diff[DW-1]) begin
      verdict_o = '{pass: 1'b1, colour: COLOUR_GREEN};
    end else if ({1'b0, actual} > xburst_ext) begin
      verdict_o = '{pass: 1'b0, colour: COLOUR_RED_ACTUAL};
      level_o   = level_i;
      debt_o    = '0;
    end else if (compounded > xburst_ext) begin
      verdict_o = '{pass: 1'b0, colour: COLOUR_RED_COMPOUNDED};
      level_o   = level_i;
      debt_o    = '0;
    end else begin
      verdict_o = '{pass: 1'b1, colour: COLOUR_YELLOW};
      debt_o    = compounded[BYTE_COUNT_WIDTH-1:0];
    end
  end

endmodule

/* dv/car_token_bucket_policer_top_test.sv */
// Self-checking testbench for the committed access rate token bucket policer top level.
module car_token_bucket_policer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ctbp_pkg::*;

  localparam int TIME_W          = DEF_TIME_WIDTH;
  localparam int IN_W            = 64;
  localparam int CFG_W           = 32;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam longint unsigned REFILL_CEILING = 64'd1 << (DEF_BYTE_COUNT_WIDTH + 2);

  logic                       clk;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [IN_W-1:0]            in_tdata   = '0;  // now_ms, packet_bytes
  logic                       in_tuser   = 1'b0; // already_blocked
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0] out_tdata;        // pass, colour
  logic                       cfg_wr_en  = 1'b0;
  logic [CFG_IDX_WIDTH-1:0]   cfg_index  = CFG_COMMITTED_RATE;
  logic [CFG_W-1:0]           cfg_data   = '0;

  car_token_bucket_policer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // bucket state and registers as the policer should hold them
  longint            bucket_level = 0;
  longint unsigned   debt_total   = 0;
  logic [TIME_W-1:0] refill_stamp = '0;
  logic [23:0]       rate_reg     = '0;
  logic [31:0]       cbs_reg      = '0;
  logic [31:0]       ebs_reg      = '0;

  verdict_t          verdict_queue[$];
  int                mismatch_count    = 0;
  int                colour_seen[5]    = '{default: 0};
  int                send_idle_pct     = 0;
  int                recv_stall_pct    = 0;
  int                hold_off_requests = 0;
  int                hold_off_served   = 0;
  int                hold_left         = 0;
  logic [TIME_W-1:0] pkt_clock         = '0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("timeout with %0d verdicts outstanding", verdict_queue.size());
    $display("simulation failed");
    $finish;
  end

  function automatic verdict_t police_packet(input logic [TIME_W-1:0] now,
                                             input logic [15:0] len, input logic blk);
    verdict_t        v;
    longint unsigned elapsed;
    longint unsigned gain;
    longint unsigned shortfall;
    longint unsigned debt_sum;
    longint          level;
    longint          len_l;
    len_l = longint'({48'd0, len});
    if (blk) begin
      v.pass   = 1'b0;
      v.colour = COLOUR_BYPASSED;
      return v;
    end
    if (now > refill_stamp) begin
      elapsed = 64'(now) - 64'(refill_stamp);
      if (rate_reg != 0 && elapsed > REFILL_CEILING / rate_reg) begin
        gain = REFILL_CEILING;
      end else begin
        gain = elapsed * rate_reg;
        if (gain > REFILL_CEILING) gain = REFILL_CEILING;
      end
      level = bucket_level + longint'(gain);
      if (level > longint'({32'd0, cbs_reg})) level = longint'({32'd0, cbs_reg});
      bucket_level = level;
      refill_stamp = now;
    end
    if (bucket_level - len_l >= 0) begin
      bucket_level = bucket_level - len_l;
      v.pass   = 1'b1;
      v.colour = COLOUR_GREEN;
      return v;
    end
    shortfall = len_l - bucket_level;
    debt_sum  = debt_total + shortfall;
    if (shortfall > {32'd0, ebs_reg}) begin
      debt_total = 0;
      v.pass     = 1'b0;
      v.colour   = COLOUR_RED_ACTUAL;
    end else if (debt_sum > {32'd0, ebs_reg}) begin
      debt_total = 0;
      v.pass     = 1'b0;
      v.colour   = COLOUR_RED_COMPOUNDED;
    end else begin
      bucket_level = -longint'(shortfall);
      debt_total   = debt_sum;
      v.pass       = 1'b1;
      v.colour     = COLOUR_YELLOW;
    end
    return v;
  endfunction

  // result side: check each beat, stall at random or for a requested hold-off
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_queue.size() == 0) begin
        $display("%0t: verdict beat with none expected, actual %h", $realtime, out_tdata);
        mismatch_count++;
      end else begin
        exp_v = verdict_queue.pop_front();
        if (out_tdata[0] !== exp_v.pass) begin
          $display("%0t: pass expected %0d actual %0d", $realtime, exp_v.pass, out_tdata[0]);
          mismatch_count++;
        end
        if (out_tdata[3:1] !== exp_v.colour) begin
          $display("%0t: colour expected %0d actual %0d", $realtime, exp_v.colour,
                   out_tdata[3:1]);
          mismatch_count++;
        end
        if (out_tdata[7:4] !== 4'd0) begin
          $display("%0t: padding expected 0 actual %h", $realtime, out_tdata[7:4]);
          mismatch_count++;
        end
      end
      if (out_tdata[3:1] <= COLOUR_BYPASSED) colour_seen[out_tdata[3:1]]++;
    end
    if (hold_off_requests != hold_off_served) begin
      hold_off_served = hold_off_requests;
      hold_left       = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic write_register(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_COMMITTED_RATE:  rate_reg = value[23:0];
      CFG_COMMITTED_BURST: cbs_reg  = value;
      CFG_EXTENDED_BURST:  ebs_reg  = value;
      default: ;
    endcase
  endtask

  task automatic send_packet(input logic [TIME_W-1:0] now, input logic [15:0] len,
                             input logic blk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {len, now};
    in_tuser  <= blk;
    do @(posedge clk); while (!in_tready);
    verdict_queue.push_back(police_packet(now, len, blk));
  endtask

  // stop sending and hold until every verdict is back
  task automatic wait_for_verdicts;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic pick_policy;
    logic [31:0] rate_v;
    logic [31:0] cbs_v;
    logic [31:0] ebs_v;
    case ($urandom_range(9))
      0:       rate_v = 0;
      1:       rate_v = 32'h00FF_FFFF;
      default: rate_v = $urandom_range(100, 3000);
    endcase
    case ($urandom_range(9))
      0:       cbs_v = 0;
      1:       cbs_v = 32'hFFFF_FFFF;
      default: cbs_v = $urandom_range(0, 20000);
    endcase
    case ($urandom_range(9))
      0:       ebs_v = 0;
      1:       ebs_v = 32'hFFFF_FFFF;
      default: ebs_v = $urandom_range(0, 20000);
    endcase
    write_register(CFG_COMMITTED_RATE, rate_v);
    write_register(CFG_COMMITTED_BURST, cbs_v);
    write_register(CFG_EXTENDED_BURST, ebs_v);
  endtask

  task automatic send_random_traffic(input int count);
    int          pick;
    logic [15:0] len;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      case ($urandom_range(49))
        0:       len = 16'd0;
        1:       len = 16'hFFFF;
        2:       len = 16'($urandom);
        default: len = 16'($urandom_range(40, 1500));
      endcase
      if (pick < 4) begin
        send_packet(TIME_W'({$urandom, $urandom}), 16'($urandom), 1'b1);
      end else if (pick < 6) begin
        pkt_clock = TIME_W'({$urandom, $urandom});
        send_packet(pkt_clock, len, 1'b0);
      end else begin
        pkt_clock = pkt_clock + (($urandom_range(19) == 0) ? $urandom_range(5000)
                                                              : $urandom_range(3));
        send_packet(pkt_clock, len, 1'b0);
      end
    end
  endtask

  task automatic test_directed_cases;
    set_idling(0, 0);
    send_packet(48'd0, 16'd0, 1'b0);
    send_packet(48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
    send_packet(48'd5, 16'd1, 1'b0);
    wait_for_verdicts();
    write_register(CFG_COMMITTED_RATE, 32'd1000);
    write_register(CFG_COMMITTED_BURST, 32'd3000);
    write_register(CFG_EXTENDED_BURST, 32'd2000);
    send_packet(48'd6, 16'd1500, 1'b0);
    send_packet(48'd6, 16'd1000, 1'b0);
    send_packet(48'd6, 16'd100, 1'b0);
    send_packet(48'd6, 16'd600, 1'b0);
    send_packet(48'd20, 16'd1, 1'b0);
    send_packet(48'd0, 16'd0, 1'b0);
    wait_for_verdicts();
    write_register(CFG_COMMITTED_RATE, 32'h00FF_FFFF);
    send_packet(48'h8000_0000_0000, 16'hFFFF, 1'b0);
    wait_for_verdicts();
    write_register(CFG_COMMITTED_BURST, 32'hFFFF_FFFF);
    write_register(CFG_EXTENDED_BURST, 32'hFFFF_FFFF);
    send_packet(48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b0);
    send_packet(48'd1, 16'd0, 1'b0);
    wait_for_verdicts();
    write_register(CFG_COMMITTED_BURST, 32'd100);
    send_packet(48'd1, 16'd10, 1'b0);
    send_packet(48'd2, 16'd0, 1'b0);
    send_packet(48'd2, 16'hFFFF, 1'b0);
    send_packet(48'd2, 16'd0, 1'b1);
    wait_for_verdicts();
    pkt_clock = 48'd2;
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct, input int count);
    set_idling(send_pct, recv_pct);
    for (int k = 0; k < 2; k++) begin
      wait_for_verdicts();
      pick_policy();
      send_random_traffic(count / 2);
    end
    wait_for_verdicts();
  endtask

  task automatic test_backpressure;
    set_idling(0, 0);
    pick_policy();
    hold_off_requests <= hold_off_requests + 1;
    send_random_traffic(60);
    wait_for_verdicts();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_phase(0, 0, 390);
    test_random_phase(79, 0, 390);
    test_random_phase(0, 79, 390);
    test_random_phase(22, 22, 390);
    test_backpressure();
    repeat (8) @(posedge clk);
    if (verdict_queue.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $realtime, verdict_queue.size());
      mismatch_count++;
    end
    $display("policed %0d green, %0d yellow, %0d red on debt, %0d red on compounded debt,",
             colour_seen[COLOUR_GREEN], colour_seen[COLOUR_YELLOW],
             colour_seen[COLOUR_RED_ACTUAL], colour_seen[COLOUR_RED_COMPOUNDED]);
    $display("%0d bypassed, across idle and stall mixes, extreme rates and bursts, hold-off",
             colour_seen[COLOUR_BYPASSED]);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
